// ===== rtl/core/vfde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfde_pkg
// shared types, command codes and sizes of the voxel frame draw engine
// ----------------------------------------------------------------------------
package vfde_pkg;

  localparam int VFD_SIDE = 8;

  localparam logic [3:0] OP_SET     = 4'd0;
  localparam logic [3:0] OP_CLR     = 4'd1;
  localparam logic [3:0] OP_FLIP    = 4'd2;
  localparam logic [3:0] OP_WRITE   = 4'd3;
  localparam logic [3:0] OP_READ    = 4'd4;
  localparam logic [3:0] OP_SETPL   = 4'd5;
  localparam logic [3:0] OP_CLRPL   = 4'd6;
  localparam logic [3:0] OP_FILL    = 4'd7;
  localparam logic [3:0] OP_BOXF    = 4'd8;
  localparam logic [3:0] OP_BOXW    = 4'd9;
  localparam logic [3:0] OP_BOXE    = 4'd10;
  localparam logic [3:0] OP_SHIFT   = 4'd11;
  localparam logic [3:0] OP_MIRROR  = 4'd12;
  localparam logic [3:0] OP_COPY    = 4'd13;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic [7:0] WRITE_ON = 8'h01;

  typedef struct packed {
    logic [3:0] opcode;
    logic [2:0] x_start;
    logic [2:0] y_start;
    logic [2:0] z_start;
    logic [2:0] x_end;
    logic [2:0] y_end;
    logic [2:0] z_end;
    logic [1:0] axis_select;
    logic [2:0] plane_num;
    logic       shift_up;
    logic [7:0] fill_byte;
    logic       use_scratch;
  } in_t;

  typedef struct packed {
    logic       voxel_on;
    logic [3:0] echo_op;
  } out_t;

  // position of the row being worked on
  typedef struct packed {
    logic [2:0] z;
    logic [2:0] y;
    logic       src_zero;
  } row_pos_t;

endpackage

// ===== rtl/core/vfde_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfde_mem
// row store, one write and one registered read port, cleared by valid bits
// ----------------------------------------------------------------------------
module vfde_mem #(
  parameter int AW = 6,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [DW-1:0]    rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // a row never written reads as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/vfde_row_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfde_row_alu
// new value of one row byte for the current command
// ----------------------------------------------------------------------------
module vfde_row_alu import vfde_pkg::*; #(
  parameter int SIDE = VFD_SIDE
) (
  input  in_t             cmd,
  input  row_pos_t        pos,
  input  logic [SIDE-1:0] old_row,
  output logic [SIDE-1:0] new_row
);

  logic [SIDE-1:0] run;
  logic [SIDE-1:0] bx1;
  logic [SIDE-1:0] bx2;
  logic [SIDE-1:0] bpl;
  logic [SIDE-1:0] rev;
  logic [SIDE-1:0] ones;
  logic            in_y, in_z, edge_y, edge_z, set_pl;

  always_comb begin
    for (int i = 0; i < SIDE; i++) begin
      run[i] = (3'(i) >= cmd.x_start) && (3'(i) <= cmd.x_end);
      bx1[i] = (3'(i) == cmd.x_start);
      bx2[i] = (3'(i) == cmd.x_end);
      bpl[i] = (3'(i) == cmd.plane_num);
      rev[i] = old_row[SIDE-1-i];
    end
  end

  assign ones   = '1;
  assign in_y   = (pos.y >= cmd.y_start) && (pos.y <= cmd.y_end);
  assign in_z   = (pos.z >= cmd.z_start) && (pos.z <= cmd.z_end);
  assign edge_y = (pos.y == cmd.y_start) || (pos.y == cmd.y_end);
  assign edge_z = (pos.z == cmd.z_start) || (pos.z == cmd.z_end);
  assign set_pl = (cmd.opcode == OP_SETPL);

  always_comb begin
    new_row = old_row;
    case (cmd.opcode)
      OP_SET:   new_row = old_row | bx1;
      OP_CLR:   new_row = old_row & ~bx1;
      OP_FLIP:  new_row = old_row ^ bx1;
      OP_WRITE: new_row = (cmd.fill_byte == WRITE_ON) ? (old_row | bx1) : (old_row & ~bx1);
      OP_SETPL, OP_CLRPL: begin
        case (cmd.axis_select)
          AXIS_X:  new_row = set_pl ? (old_row | bpl) : (old_row & ~bpl);
          AXIS_Y:  new_row = (pos.y == cmd.plane_num) ? (set_pl ? ones : '0) : old_row;
          AXIS_Z:  new_row = (pos.z == cmd.plane_num) ? (set_pl ? ones : '0) : old_row;
          default: new_row = old_row;
        endcase
      end
      OP_FILL:  new_row = cmd.fill_byte[SIDE-1:0];
      OP_BOXF:  new_row = (in_y && in_z) ? (old_row | run) : old_row;
      OP_BOXW: begin
        if (in_y && in_z) begin
          new_row = (edge_y || edge_z) ? run : (old_row | bx1 | bx2);
        end
      end
      OP_BOXE: begin
        if (edge_y && edge_z) begin
          new_row = run;
        end else if ((edge_z && in_y) || (edge_y && in_z)) begin
          new_row = old_row | bx1 | bx2;
        end
      end
      OP_SHIFT: begin
        if (cmd.axis_select == AXIS_X) begin
          new_row = cmd.shift_up ? (old_row << 1) : (old_row >> 1);
        end else begin
          new_row = pos.src_zero ? '0 : old_row;
        end
      end
      OP_MIRROR: new_row = (cmd.axis_select == AXIS_X) ? rev : old_row;
      default:   new_row = old_row;
    endcase
  end

endmodule

// ===== rtl/core/voxel_frame_draw_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_frame_draw_engine
// voxel cube frame and scratch frame in row memories, one command per item
// ----------------------------------------------------------------------------
// sequence: single-voxel commands read their row, then write it (read only
// samples the voxel); commands that change nothing go straight to the
// result; whole-frame commands read then write each row in turn through the
// registered memory read port; mirror on Y or Z reads a row and its partner,
// then writes both, and skips the other half. one item at a time, the next is
// taken the cycle after the result is registered; a held result stalls it.
// reset: synchronous active-low rst_n clears both frames through valid bits
// at once; no clearing pass.
// ----------------------------------------------------------------------------
module voxel_frame_draw_engine import vfde_pkg::*; #(
  parameter int SIDE = VFD_SIDE
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int CW = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int AW = 2 * CW;
  localparam logic [CW-1:0] LAST = CW'(SIDE - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_RD2  = 6'b000100,
    S_WR   = 6'b001000,
    S_WR2  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  in_t             cmd_r, cmd_nxt;
  logic [CW-1:0]   zc_r, zc_nxt, yc_r, yc_nxt;
  logic            single_r, single_nxt;
  logic            voxel_r, voxel_nxt;
  logic [SIDE-1:0] hold_r, hold_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_data_r, out_data_nxt;

  logic [CW-1:0]   cur_z, cur_y, src_z, src_y, par_z, par_y;
  logic            src_zero, shift_yz, mirror_yz, mirror_skip, wr_scr, rd_scr;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [SIDE-1:0] wr_data, fr_rd, sc_rd, rd_row, alu_row, rd_shift;
  row_pos_t        pos;
  logic            inr, last_row;
  in_t             srt;

  // row walk order: descending along the shift axis when moving up
  always_comb begin
    shift_yz  = (cmd_r.opcode == OP_SHIFT) &&
                ((cmd_r.axis_select == AXIS_Y) || (cmd_r.axis_select == AXIS_Z));
    mirror_yz = (cmd_r.opcode == OP_MIRROR) &&
                ((cmd_r.axis_select == AXIS_Y) || (cmd_r.axis_select == AXIS_Z));
    cur_z = (shift_yz && cmd_r.shift_up && cmd_r.axis_select == AXIS_Z) ? LAST - zc_r : zc_r;
    cur_y = (shift_yz && cmd_r.shift_up && cmd_r.axis_select == AXIS_Y) ? LAST - yc_r : yc_r;
    src_z = cur_z;
    src_y = cur_y;
    src_zero = 1'b0;
    if (shift_yz) begin
      if (cmd_r.axis_select == AXIS_Y) begin
        src_y    = cmd_r.shift_up ? CW'(cur_y - 1'b1) : CW'(cur_y + 1'b1);
        src_zero = cmd_r.shift_up ? (cur_y == '0) : (cur_y == LAST);
      end else begin
        src_z    = cmd_r.shift_up ? CW'(cur_z - 1'b1) : CW'(cur_z + 1'b1);
        src_zero = cmd_r.shift_up ? (cur_z == '0) : (cur_z == LAST);
      end
    end
    par_z = (cmd_r.axis_select == AXIS_Z) ? LAST - cur_z : cur_z;
    par_y = (cmd_r.axis_select == AXIS_Y) ? LAST - cur_y : cur_y;
    mirror_skip = (cmd_r.axis_select == AXIS_Y) ? (cur_y >= par_y) : (cur_z >= par_z);
    wr_scr = cmd_r.use_scratch && ((cmd_r.opcode == OP_SET) || (cmd_r.opcode == OP_CLR) ||
                                   (cmd_r.opcode == OP_FILL));
    rd_scr = wr_scr || (cmd_r.opcode == OP_COPY);
    last_row = single_r || ((zc_r == LAST) && (yc_r == LAST));
  end

  assign rd_row = rd_scr ? sc_rd : fr_rd;
  assign pos = '{z: 3'(cur_z), y: 3'(cur_y), src_zero: src_zero};
  assign rd_shift = rd_row >> cmd_r.x_start;

  assign inr = ({1'b0, in_data.x_start} < 4'(SIDE)) && ({1'b0, in_data.y_start} < 4'(SIDE)) &&
               ({1'b0, in_data.z_start} < 4'(SIDE));

  // box corners sorted on entry
  always_comb begin
    srt = in_data;
    if (in_data.x_start > in_data.x_end) begin
      srt.x_start = in_data.x_end;
      srt.x_end   = in_data.x_start;
    end
    if (in_data.y_start > in_data.y_end) begin
      srt.y_start = in_data.y_end;
      srt.y_end   = in_data.y_start;
    end
    if (in_data.z_start > in_data.z_end) begin
      srt.z_start = in_data.z_end;
      srt.z_end   = in_data.z_start;
    end
  end

  vfde_row_alu #(.SIDE(SIDE)) u_alu (
    .cmd     (cmd_r),
    .pos     (pos),
    .old_row (rd_row),
    .new_row (alu_row)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    zc_nxt        = zc_r;
    yc_nxt        = yc_r;
    single_nxt    = single_r;
    voxel_nxt     = voxel_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = {cur_z, cur_y};
    wr_en         = 1'b0;
    wr_addr       = {cur_z, cur_y};
    wr_data       = alu_row;
    in_ready      = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_data;
          voxel_nxt  = 1'b0;
          single_nxt = 1'b0;
          zc_nxt     = '0;
          yc_nxt     = '0;
          state_nxt  = S_DONE;
          case (in_data.opcode)
            OP_SET, OP_CLR, OP_FLIP, OP_WRITE, OP_READ: begin
              if (inr) begin
                single_nxt = 1'b1;
                zc_nxt     = in_data.z_start[CW-1:0];
                yc_nxt     = in_data.y_start[CW-1:0];
                state_nxt  = S_RD;
              end
            end
            OP_SETPL, OP_CLRPL: begin
              if (in_data.axis_select != AXIS_NONE &&
                  {1'b0, in_data.plane_num} < 4'(SIDE)) begin
                state_nxt = S_RD;
              end
            end
            OP_SHIFT, OP_MIRROR: begin
              if (in_data.axis_select != AXIS_NONE) begin
                state_nxt = S_RD;
              end
            end
            OP_FILL, OP_COPY: state_nxt = S_RD;
            OP_BOXF, OP_BOXW, OP_BOXE: begin
              cmd_nxt   = srt;
              state_nxt = S_RD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RD: begin
        if (mirror_yz && mirror_skip) begin
          state_nxt = S_WR2;
          if (last_row) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
            if (yc_r == LAST) begin
              yc_nxt = '0;
              zc_nxt = CW'(zc_r + 1'b1);
            end else begin
              yc_nxt = CW'(yc_r + 1'b1);
            end
          end
        end else begin
          rd_en     = 1'b1;
          rd_addr   = shift_yz ? {src_z, src_y} : {cur_z, cur_y};
          state_nxt = mirror_yz ? S_RD2 : S_WR;
        end
      end
      S_RD2: begin
        hold_nxt  = rd_row;
        rd_en     = 1'b1;
        rd_addr   = {par_z, par_y};
        state_nxt = S_WR;
      end
      S_WR, S_WR2: begin
        if (state_r == S_WR2) begin
          wr_en   = 1'b1;
          wr_addr = {par_z, par_y};
          wr_data = hold_r;
        end else if (cmd_r.opcode == OP_READ) begin
          voxel_nxt = rd_shift[0];
        end else begin
          wr_en = 1'b1;
        end
        if (state_r == S_WR && mirror_yz) begin
          state_nxt = S_WR2;
        end else if (last_row) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RD;
          if (yc_r == LAST) begin
            yc_nxt = '0;
            zc_nxt = CW'(zc_r + 1'b1);
          end else begin
            yc_nxt = CW'(yc_r + 1'b1);
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{voxel_on: voxel_r, echo_op: cmd_r.opcode};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      single_r    <= 1'b0;
      zc_r        <= '0;
      yc_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      single_r    <= single_nxt;
      zc_r        <= zc_nxt;
      yc_r        <= yc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    voxel_r    <= voxel_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  vfde_mem #(.AW(AW), .DW(SIDE)) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (fr_rd),
    .wr_en   (wr_en && !wr_scr),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  vfde_mem #(.AW(AW), .DW(SIDE)) u_scratch (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (sc_rd),
    .wr_en   (wr_en && wr_scr),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while a command was still running");

  a_voxel_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.voxel_on) |-> (out_data.echo_op == OP_READ))
    else $error("voxel_on raised for a command other than read");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !wr_en)
    else $error("row write outside a command");

  a_single_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (single_r && state_r == S_WR) |=> (state_r == S_DONE))
    else $error("single-voxel command touched more than one row");

endmodule
